[hdl/lu3_pkg.sv]
// Shared types for the 3x3 block LU factor pipeline.
`default_nettype none
package lu3_pkg;

   localparam int WORD_W  = 32;
   localparam int SIGMA_W = 31;
   localparam int PROD_W  = 64;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [SIGMA_W-1:0]       sigma_type;

   typedef struct packed {
      word_type m00;
      word_type m01;
      word_type m02;
      word_type m10;
      word_type m11;
      word_type m12;
      word_type m20;
      word_type m21;
      word_type m22;
      logic     last_in;
   } req_type;

   typedef struct packed {
      word_type f00;
      word_type f01;
      word_type f02;
      word_type f10;
      word_type f11;
      word_type f12;
      word_type f20;
      word_type f21;
      word_type f22;
      logic     singular;
      logic     last_out;
   } rsp_type;

   typedef struct packed {
      word_type a00;
      word_type a01;
      word_type a02;
      word_type a10;
      word_type a11;
      word_type a12;
      word_type a20;
      word_type a21;
      word_type a22;
      logic     last;
      logic     flag;
   } mat_type;

   typedef struct packed {
      logic     ovf;
      word_type val;
   } sat_type;

endpackage
`default_nettype wire

[hdl/lu3_chan_if.sv]
// Valid/ready channel carrying one payload per transfer.
`default_nettype none
interface lu3_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hdl/lu3_recip.sv]
// Pipelined fixed-point reciprocal, one quotient bit per stage, with sideband.
`default_nettype none
module lu3_recip
   import lu3_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int SIDE_W    = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  word_type          x,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_vld,
   output word_type          r,
   output logic              ovf,
   output logic [SIDE_W-1:0] side_out
);

   localparam int QB    = WORD_W;
   localparam int REM_W = 2 * WORD_W;

   logic              vld_ff  [0:QB];
   logic [REM_W-1:0]  rem_ff  [0:QB];
   logic [QB-1:0]     q_ff    [0:QB];
   logic [WORD_W-1:0] mag_ff  [0:QB];
   logic              neg_ff  [0:QB];
   logic              zero_ff [0:QB];
   logic              big_ff  [0:QB];
   logic [SIDE_W-1:0] side_ff [0:QB];

   logic [WORD_W-1:0] mag_in;
   logic [REM_W-1:0]  num_in;
   logic              big_in;

   always_comb begin
      mag_in = x[WORD_W-1] ? (~x + WORD_W'(1)) : x;
      num_in = (REM_W'(1) << (2 * FRAC_BITS)) + REM_W'(mag_in[WORD_W-1:1]);
      big_in = num_in >= {mag_in, {QB{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= num_in;
         q_ff[0]    <= '0;
         mag_ff[0]  <= mag_in;
         neg_ff[0]  <= x[WORD_W-1];
         zero_ff[0] <= (x == '0);
         big_ff[0]  <= big_in;
         side_ff[0] <= side_in;
      end
   end

   for (genvar s = 1; s <= QB; s++) begin : g_div
      logic [REM_W-1:0] dv;
      logic             take;

      always_comb begin
         dv   = REM_W'(mag_ff[s-1]) << (QB - s);
         take = rem_ff[s-1] >= dv;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= take ? (rem_ff[s-1] - dv) : rem_ff[s-1];
            q_ff[s]    <= {q_ff[s-1][QB-2:0], take};
            mag_ff[s]  <= mag_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
            zero_ff[s] <= zero_ff[s-1];
            big_ff[s]  <= big_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   logic              out_vld_ff;
   word_type          r_ff;
   logic              ovf_ff;
   logic [SIDE_W-1:0] side_out_ff;
   word_type          r_in;
   logic              ovf_in;
   logic [QB-1:0]     qv;

   always_comb begin
      qv     = q_ff[QB];
      ovf_in = 1'b0;
      r_in   = '0;
      if (zero_ff[QB]) begin
         ovf_in = 1'b1;
         r_in   = {1'b0, {(WORD_W-1){1'b1}}};
      end else if (neg_ff[QB]) begin
         if (big_ff[QB] || (qv > {1'b1, {(QB-1){1'b0}}})) begin
            ovf_in = 1'b1;
            r_in   = {1'b1, {(WORD_W-1){1'b0}}};
         end else begin
            r_in = ~qv + WORD_W'(1);
         end
      end else begin
         if (big_ff[QB] || qv[QB-1]) begin
            ovf_in = 1'b1;
            r_in   = {1'b0, {(WORD_W-1){1'b1}}};
         end else begin
            r_in = qv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff        <= r_in;
         ovf_ff      <= ovf_in;
         side_out_ff <= side_ff[QB];
      end
   end

   assign out_vld  = out_vld_ff;
   assign r        = r_ff;
   assign ovf      = ovf_ff;
   assign side_out = side_out_ff;

endmodule
`default_nettype wire

[hdl/block_lu_3x3_factor.sv]
// Top level: pipelined Doolittle LU factor of one scaled 3x3 block per cycle while the output is not stalled.
`default_nettype none
// Accepts one 3x3 block per clock while the output is not stalled and returns
// its factored form through the diagonal product and rounding stages, three
// reciprocal pipelines (one quotient bit per stage), four multiply/round
// stages between the first and second pivot, four between the second and
// third, and the output register. All stages share one enable, so a stalled
// output holds the whole pipeline; no transfer is lost or repeated. The
// diagonal scale is written through the csr channel, which is always ready.
module block_lu_3x3_factor
   import lu3_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   lu3_chan_if.sink   req_if,
   lu3_chan_if.source rsp_if,
   lu3_chan_if.sink   csr_if
);

   localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
   localparam sigma_type SIGMA_RESET = SIGMA_W'(1) << FRAC_BITS;

   function automatic logic signed [PROD_W-1:0] rnd(input logic signed [PROD_W-1:0] p);
      return (p + RND_HALF) >>> FRAC_BITS;
   endfunction

   function automatic sat_type sat(input logic signed [PROD_W-1:0] v);
      sat_type res;
      res.ovf = !((&v[PROD_W-1:WORD_W-1]) || !(|v[PROD_W-1:WORD_W-1]));
      if (res.ovf) begin
         res.val = v[PROD_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
      end else begin
         res.val = v[WORD_W-1:0];
      end
      return res;
   endfunction

   function automatic logic signed [PROD_W-1:0] mul(input word_type a, input word_type b);
      return PROD_W'(a) * PROD_W'(b);
   endfunction

   // configuration
   sigma_type sigma_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff <= SIGMA_RESET;
      end else if (csr_if.valid) begin
         sigma_ff <= csr_if.payload;
      end
   end

   assign csr_if.ready = 1'b1;

   // pipeline control
   logic    en;
   logic    rsp_vld_ff;
   rsp_type rsp_ff;

   assign en           = !rsp_vld_ff || rsp_if.ready;
   assign req_if.ready = en;

   // stage 1: diagonal products
   logic                     v1_ff;
   mat_type                  m1_ff;
   logic signed [PROD_W-1:0] p0_ff, p1_ff, p2_ff;
   mat_type                  m1_in;
   word_type                 sig_w;

   always_comb begin
      sig_w        = {1'b0, sigma_ff};
      m1_in.a00    = req_if.payload.m00;
      m1_in.a01    = req_if.payload.m01;
      m1_in.a02    = req_if.payload.m02;
      m1_in.a10    = req_if.payload.m10;
      m1_in.a11    = req_if.payload.m11;
      m1_in.a12    = req_if.payload.m12;
      m1_in.a20    = req_if.payload.m20;
      m1_in.a21    = req_if.payload.m21;
      m1_in.a22    = req_if.payload.m22;
      m1_in.last   = req_if.payload.last_in;
      m1_in.flag   = 1'b0;
   end

   // stage 2: round the diagonal
   logic    v2_ff;
   mat_type m2_ff, m2_in;
   sat_type s20, s21, s22;

   always_comb begin
      s20        = sat(rnd(p0_ff));
      s21        = sat(rnd(p1_ff));
      s22        = sat(rnd(p2_ff));
      m2_in      = m1_ff;
      m2_in.a00  = s20.val;
      m2_in.a11  = s21.val;
      m2_in.a22  = s22.val;
      m2_in.flag = m1_ff.flag | s20.ovf | s21.ovf | s22.ovf;
   end

   // first pivot reciprocal
   logic     r0_vld, r0_ovf;
   word_type r0_val;
   mat_type  r0_side;

   lu3_recip #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(mat_type))) u_recip0 (
      .clock, .reset, .en,
      .in_vld(v2_ff), .x(m2_ff.a00), .side_in(m2_ff),
      .out_vld(r0_vld), .r(r0_val), .ovf(r0_ovf), .side_out(r0_side)
   );

   // stage 3: column 0 multiplier products
   logic                     v3_ff;
   mat_type                  m3_ff, m3_in;
   logic signed [PROD_W-1:0] q10_ff, q20_ff;

   always_comb begin
      m3_in      = r0_side;
      m3_in.a00  = r0_val;
      m3_in.flag = r0_side.flag | r0_ovf;
   end

   // stage 4: round column 0 multipliers
   logic    v4_ff;
   mat_type m4_ff, m4_in;
   sat_type s40, s41;

   always_comb begin
      s40        = sat(rnd(q10_ff));
      s41        = sat(rnd(q20_ff));
      m4_in      = m3_ff;
      m4_in.a10  = s40.val;
      m4_in.a20  = s41.val;
      m4_in.flag = m3_ff.flag | s40.ovf | s41.ovf;
   end

   // stage 5: trailing update products
   logic                     v5_ff;
   mat_type                  m5_ff;
   logic signed [PROD_W-1:0] q11_ff, q12_ff, q21_ff, q22_ff;

   // stage 6: trailing update subtract
   logic    v6_ff;
   mat_type m6_ff, m6_in;
   sat_type s60, s61, s62, s63;

   always_comb begin
      s60        = sat(PROD_W'(m5_ff.a11) - rnd(q11_ff));
      s61        = sat(PROD_W'(m5_ff.a12) - rnd(q12_ff));
      s62        = sat(PROD_W'(m5_ff.a21) - rnd(q21_ff));
      s63        = sat(PROD_W'(m5_ff.a22) - rnd(q22_ff));
      m6_in      = m5_ff;
      m6_in.a11  = s60.val;
      m6_in.a12  = s61.val;
      m6_in.a21  = s62.val;
      m6_in.a22  = s63.val;
      m6_in.flag = m5_ff.flag | s60.ovf | s61.ovf | s62.ovf | s63.ovf;
   end

   // second pivot reciprocal
   logic     r1_vld, r1_ovf;
   word_type r1_val;
   mat_type  r1_side;

   lu3_recip #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(mat_type))) u_recip1 (
      .clock, .reset, .en,
      .in_vld(v6_ff), .x(m6_ff.a11), .side_in(m6_ff),
      .out_vld(r1_vld), .r(r1_val), .ovf(r1_ovf), .side_out(r1_side)
   );

   // stage 7: row 2 column 1 product
   logic                     v7_ff;
   mat_type                  m7_ff, m7_in;
   logic signed [PROD_W-1:0] q7_ff;

   always_comb begin
      m7_in      = r1_side;
      m7_in.a11  = r1_val;
      m7_in.flag = r1_side.flag | r1_ovf;
   end

   // stage 8: round row 2 column 1 multiplier
   logic    v8_ff;
   mat_type m8_ff, m8_in;
   sat_type s80;

   always_comb begin
      s80        = sat(rnd(q7_ff));
      m8_in      = m7_ff;
      m8_in.a21  = s80.val;
      m8_in.flag = m7_ff.flag | s80.ovf;
   end

   // stage 9: last update product
   logic                     v9_ff;
   mat_type                  m9_ff;
   logic signed [PROD_W-1:0] q9_ff;

   // stage 10: last update subtract
   logic    v10_ff;
   mat_type m10_ff, m10_in;
   sat_type s100;

   always_comb begin
      s100        = sat(PROD_W'(m9_ff.a22) - rnd(q9_ff));
      m10_in      = m9_ff;
      m10_in.a22  = s100.val;
      m10_in.flag = m9_ff.flag | s100.ovf;
   end

   // third pivot reciprocal
   logic     r2_vld, r2_ovf;
   word_type r2_val;
   mat_type  r2_side;

   lu3_recip #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(mat_type))) u_recip2 (
      .clock, .reset, .en,
      .in_vld(v10_ff), .x(m10_ff.a22), .side_in(m10_ff),
      .out_vld(r2_vld), .r(r2_val), .ovf(r2_ovf), .side_out(r2_side)
   );

   rsp_type rsp_in;

   always_comb begin
      rsp_in.f00      = r2_side.a00;
      rsp_in.f01      = r2_side.a01;
      rsp_in.f02      = r2_side.a02;
      rsp_in.f10      = r2_side.a10;
      rsp_in.f11      = r2_side.a11;
      rsp_in.f12      = r2_side.a12;
      rsp_in.f20      = r2_side.a20;
      rsp_in.f21      = r2_side.a21;
      rsp_in.f22      = r2_val;
      rsp_in.singular = r2_side.flag | r2_ovf;
      rsp_in.last_out = r2_side.last;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         v5_ff      <= 1'b0;
         v6_ff      <= 1'b0;
         v7_ff      <= 1'b0;
         v8_ff      <= 1'b0;
         v9_ff      <= 1'b0;
         v10_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         v1_ff      <= req_if.valid;
         v2_ff      <= v1_ff;
         v3_ff      <= r0_vld;
         v4_ff      <= v3_ff;
         v5_ff      <= v4_ff;
         v6_ff      <= v5_ff;
         v7_ff      <= r1_vld;
         v8_ff      <= v7_ff;
         v9_ff      <= v8_ff;
         v10_ff     <= v9_ff;
         rsp_vld_ff <= r2_vld;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff  <= m1_in;
         p0_ff  <= mul(req_if.payload.m00, sig_w);
         p1_ff  <= mul(req_if.payload.m11, sig_w);
         p2_ff  <= mul(req_if.payload.m22, sig_w);
         m2_ff  <= m2_in;
         m3_ff  <= m3_in;
         q10_ff <= mul(m3_in.a10, m3_in.a00);
         q20_ff <= mul(m3_in.a20, m3_in.a00);
         m4_ff  <= m4_in;
         m5_ff  <= m4_ff;
         q11_ff <= mul(m4_ff.a10, m4_ff.a01);
         q12_ff <= mul(m4_ff.a10, m4_ff.a02);
         q21_ff <= mul(m4_ff.a20, m4_ff.a01);
         q22_ff <= mul(m4_ff.a20, m4_ff.a02);
         m6_ff  <= m6_in;
         m7_ff  <= m7_in;
         q7_ff  <= mul(m7_in.a21, m7_in.a11);
         m8_ff  <= m8_in;
         m9_ff  <= m8_ff;
         q9_ff  <= mul(m8_ff.a21, m8_ff.a12);
         m10_ff <= m10_in;
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid   = rsp_vld_ff;
   assign rsp_if.payload = rsp_ff;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_if.ready) |=> (rsp_vld_ff && $stable(rsp_ff) && $stable(v1_ff)))
      else $error("pipeline moved while output stalled");

   a_recip_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_ff.f00 != '0 && rsp_ff.f11 != '0 && rsp_ff.f22 != '0))
      else $error("reciprocal field is zero");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!rsp_vld_ff && !v1_ff && !v10_ff))
      else $error("valid bits not cleared by reset");

endmodule
`default_nettype wire

[tb/testbench.sv]
// Testbench for the 3x3 block LU factor: predicts each factored block and checks every transfer.
`default_nettype none
module testbench;
   import lu3_pkg::*;

   localparam int FRAC = 16;
   localparam int LATENCY = 113;
   localparam int RANDOM_ITEMS = 1800;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lu3_chan_if #(.payload_type(req_type))   req_if ();
   lu3_chan_if #(.payload_type(rsp_type))   rsp_if ();
   lu3_chan_if #(.payload_type(sigma_type)) csr_if ();

   block_lu_3x3_factor #(.FRAC_BITS(FRAC)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_type   pending_blocks[$];
   rsp_type   expected_factors[$];
   sigma_type sigma_model;
   sigma_type sigma_pending;
   logic      sigma_write;
   int        errors = 0;
   int        blocks_sent = 0;
   int        blocks_checked = 0;
   int        singular_seen = 0;
   int        sender_gap = 0;
   int        receiver_gap = 0;
   int        hold_off = 0;
   bit        no_idle = 1'b0;

   function automatic longint sat_word(longint v, ref bit flag);
      if (v > 64'sd2147483647) begin
         flag = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         flag = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint round_q(longint p);
      return (p + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic longint recip_q(longint x, ref bit flag);
      longint mag, q;
      if (x == 0) begin
         flag = 1'b1;
         return 64'sd2147483647;
      end
      mag = x < 0 ? -x : x;
      q = ((64'sd1 <<< (2 * FRAC)) + mag / 2) / mag;
      return sat_word(x < 0 ? -q : q, flag);
   endfunction

   function automatic rsp_type factor_block(req_type m, sigma_type sigma);
      longint a[3][3];
      bit flag;
      rsp_type r;
      flag = 1'b0;
      a[0][0] = m.m00; a[0][1] = m.m01; a[0][2] = m.m02;
      a[1][0] = m.m10; a[1][1] = m.m11; a[1][2] = m.m12;
      a[2][0] = m.m20; a[2][1] = m.m21; a[2][2] = m.m22;
      for (int i = 0; i < 3; i++)
         a[i][i] = sat_word(round_q(a[i][i] * longint'({33'b0, sigma})), flag);
      for (int k = 0; k < 3; k++) begin
         a[k][k] = recip_q(a[k][k], flag);
         for (int i = k + 1; i < 3; i++) begin
            a[i][k] = sat_word(round_q(a[i][k] * a[k][k]), flag);
            for (int j = k + 1; j < 3; j++)
               a[i][j] = sat_word(a[i][j] - round_q(a[i][k] * a[k][j]), flag);
         end
      end
      r.f00 = a[0][0][31:0]; r.f01 = a[0][1][31:0]; r.f02 = a[0][2][31:0];
      r.f10 = a[1][0][31:0]; r.f11 = a[1][1][31:0]; r.f12 = a[1][2][31:0];
      r.f20 = a[2][0][31:0]; r.f21 = a[2][1][31:0]; r.f22 = a[2][2][31:0];
      r.singular = flag;
      r.last_out = m.last_in;
      return r;
   endfunction

   function automatic word_type rand_word(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
         2: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
         3: return '0;
         4: return 32'h7FFF_FFFF;
         default: return 32'h8000_0000;
      endcase
   endfunction

   function automatic req_type rand_block();
      req_type b;
      int mode;
      mode = $urandom_range(0, 9);
      mode = mode < 2 ? 0 : (mode < 6 ? 1 : (mode < 9 ? 2 : 3 + $urandom_range(0, 2)));
      b.m00 = rand_word(mode); b.m01 = rand_word(mode); b.m02 = rand_word(mode);
      b.m10 = rand_word(mode); b.m11 = rand_word(mode); b.m12 = rand_word(mode);
      b.m20 = rand_word(mode); b.m21 = rand_word(mode); b.m22 = rand_word(mode);
      if ($urandom_range(0, 15) == 0) b.m11 = '0;
      if ($urandom_range(0, 15) == 0) b.m00 = $urandom_range(0, 1) ? 32'sh0001_0000 : 32'shFFFF_0000;
      b.last_in = 1'($urandom_range(0, 1));
      return b;
   endfunction

   function automatic req_type uniform_block(word_type v, logic last);
      req_type b;
      b = '{v, v, v, v, v, v, v, v, v, last};
      return b;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.payload <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_factors.push_back(factor_block(req_if.payload, sigma_model));
            blocks_sent++;
         end
         if (!(req_if.valid && !req_if.ready)) begin
            if (sender_gap > 0) begin
               sender_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_blocks.size() > 0 && !sigma_write) begin
               if (!no_idle && $urandom_range(0, 19) == 0) begin
                  sender_gap = $urandom_range(1, 12);
                  req_if.valid <= 1'b0;
               end else begin
                  req_if.valid <= 1'b1;
                  req_if.payload <= pending_blocks.pop_front();
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off--;
         rsp_if.ready <= 1'b0;
      end else if (receiver_gap > 0) begin
         receiver_gap--;
         rsp_if.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 19) == 0) begin
         receiver_gap = $urandom_range(1, 12);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want, got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (expected_factors.size() == 0) begin
            $display("%0t: unexpected transfer %h", $time, got);
            errors++;
         end else begin
            want = expected_factors.pop_front();
            if (got.f00 !== want.f00)
               $display("%0t: f00 expected %h actual %h", $time, want.f00, got.f00);
            if (got.f01 !== want.f01)
               $display("%0t: f01 expected %h actual %h", $time, want.f01, got.f01);
            if (got.f02 !== want.f02)
               $display("%0t: f02 expected %h actual %h", $time, want.f02, got.f02);
            if (got.f10 !== want.f10)
               $display("%0t: f10 expected %h actual %h", $time, want.f10, got.f10);
            if (got.f11 !== want.f11)
               $display("%0t: f11 expected %h actual %h", $time, want.f11, got.f11);
            if (got.f12 !== want.f12)
               $display("%0t: f12 expected %h actual %h", $time, want.f12, got.f12);
            if (got.f20 !== want.f20)
               $display("%0t: f20 expected %h actual %h", $time, want.f20, got.f20);
            if (got.f21 !== want.f21)
               $display("%0t: f21 expected %h actual %h", $time, want.f21, got.f21);
            if (got.f22 !== want.f22)
               $display("%0t: f22 expected %h actual %h", $time, want.f22, got.f22);
            if (got.singular !== want.singular)
               $display("%0t: singular expected %b actual %b", $time, want.singular, got.singular);
            if (got.last_out !== want.last_out)
               $display("%0t: last_out expected %b actual %b", $time, want.last_out, got.last_out);
            if (got !== want) errors++;
            if (want.singular) singular_seen++;
            blocks_checked++;
         end
      end
   end

   // register write
   always @(posedge clock) begin
      if (reset) begin
         csr_if.valid <= 1'b0;
         csr_if.payload <= '0;
      end else if (csr_if.valid && csr_if.ready) begin
         sigma_model = csr_if.payload;
         sigma_write = 1'b0;
         csr_if.valid <= 1'b0;
      end else if (sigma_write) begin
         csr_if.valid <= 1'b1;
         csr_if.payload <= sigma_pending;
      end
   end

   task automatic drain();
      while (pending_blocks.size() > 0 || req_if.valid || expected_factors.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_sigma(sigma_type v);
      drain();
      sigma_pending = v;
      sigma_write = 1'b1;
      while (sigma_write) @(posedge clock);
      @(posedge clock);
   endtask

   initial begin
      sigma_type settings[6];
      sigma_model = sigma_type'(1 << FRAC);
      sigma_write = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      pending_blocks.push_back(uniform_block(32'sh0001_0000, 1'b0));
      pending_blocks.push_back(uniform_block(32'sh7FFF_FFFF, 1'b1));
      pending_blocks.push_back(uniform_block(32'sh8000_0000, 1'b0));
      pending_blocks.push_back(uniform_block(32'sh0000_0000, 1'b1));
      pending_blocks.push_back(uniform_block(32'shFFFF_FFFF, 1'b0));
      pending_blocks.push_back(uniform_block(32'sh0000_0001, 1'b1));
      pending_blocks.push_back('{32'sh0002_0000, 32'sh0001_0000, 32'sh0000_8000,
                                 32'sh0001_0000, 32'sh0003_0000, 32'shFFFF_0000,
                                 32'sh0000_8000, 32'shFFFF_0000, 32'sh0004_0000, 1'b1});
      pending_blocks.push_back('{32'shFFFE_0000, 32'sh0001_0000, 32'sh0001_0000,
                                 32'sh0002_0000, 32'sh0000_0000, 32'sh0001_0000,
                                 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b0});
      pending_blocks.push_back('{32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                                 32'sh0002_0000, 32'sh0004_0000, 32'sh0006_0000,
                                 32'sh0001_0000, 32'sh0001_0000, 32'sh0000_0000, 1'b0});
      pending_blocks.push_back('{32'sh0000_0003, 32'sh7FFF_0000, 32'sh8000_0000,
                                 32'sh7FFF_FFFF, 32'sh0000_0002, 32'sh7FFF_FFFF,
                                 32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFD, 1'b1});

      // hold off the receiver while the sender keeps offering
      for (int i = 0; i < 200; i++) pending_blocks.push_back(rand_block());
      hold_off = 400;
      drain();

      settings = '{31'h0000_0000, 31'h7FFF_FFFF, 31'h0000_0001, 31'h0000_8000,
                   31'h0003_0000, 31'h0001_0000};
      foreach (settings[s]) begin
         write_sigma(settings[s]);
         pending_blocks.push_back(uniform_block(32'sh0001_0000, 1'b0));
         pending_blocks.push_back(uniform_block(32'sh7FFF_FFFF, 1'b1));
         for (int i = 0; i < 40; i++) pending_blocks.push_back(rand_block());
      end

      write_sigma(sigma_type'($urandom_range(32'h0000_8000, 32'h0002_0000)));
      for (int i = 0; i < RANDOM_ITEMS - 600; i++) pending_blocks.push_back(rand_block());
      drain();
      write_sigma(sigma_type'($urandom));
      for (int i = 0; i < 100; i++) pending_blocks.push_back(rand_block());
      drain();
      write_sigma(31'h0001_0000);
      no_idle = 1'b1;
      for (int i = 0; i < 200; i++) pending_blocks.push_back(rand_block());
      drain();

      $display("Factored %0d blocks over 10 scale settings, %0d flagged singular.",
               blocks_checked, singular_seen);
      if (errors == 0 && blocks_checked == blocks_sent)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #5000000;
      $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire

[filelist.f]
hdl/lu3_pkg.sv
hdl/lu3_chan_if.sv
hdl/lu3_recip.sv
hdl/block_lu_3x3_factor.sv
tb/testbench.sv
